/* src/rgb_frame_point_ops_rotate_defines.svh */
// assertion helpers included by the top-level rtl file
`ifndef RGB_FRAME_POINT_OPS_ROTATE_DEFINES_SVH
`define RGB_FRAME_POINT_OPS_ROTATE_DEFINES_SVH

// same-cycle implication
`define RFPO_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RFPO_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rfpo_pkg.sv */
package rfpo_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int DIM_W       = 11;
	localparam int PIX_W       = 24;

	localparam int LIMBS   = 16;
	localparam int LIMB_W  = 32;
	localparam int LIMB_IW = $clog2(LIMBS);

	localparam logic [2:0] MODE_GREY   = 3'd0;
	localparam logic [2:0] MODE_NEG    = 3'd1;
	localparam logic [2:0] MODE_XRAY   = 3'd2;
	localparam logic [2:0] MODE_TINT   = 3'd3;
	localparam logic [2:0] MODE_ROT90  = 3'd4;
	localparam logic [2:0] MODE_ROT180 = 3'd5;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_EXP    = 2'd3;

	typedef struct packed {
		logic       done;
		logic       busy;
		logic [7:0] result;
	} xr_rsp_t;

endpackage

/* src/rfpo_store.sv */
module rfpo_store (
	input  logic                             clk,
	input  logic                             we,
	input  logic [rfpo_pkg::ADDR_W-1:0]      waddr,
	input  logic [rfpo_pkg::PIX_W-1:0]       wdata,
	input  logic                             re,
	input  logic [rfpo_pkg::ADDR_W-1:0]      raddr,
	output logic [rfpo_pkg::PIX_W-1:0]       rdata
);

	logic [rfpo_pkg::PIX_W-1:0] mem_q [rfpo_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/rfpo_xray.sv */
module rfpo_xray (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [7:0]          grey,
	input  logic [7:0]          expo,
	output rfpo_pkg::xr_rsp_t   rsp
);

	localparam logic [2:0] X_IDLE = 3'd0;
	localparam logic [2:0] X_TMUL = 3'd1;
	localparam logic [2:0] X_SCHK = 3'd2;
	localparam logic [2:0] X_SMUL = 3'd3;
	localparam logic [2:0] X_CMP  = 3'd4;

	localparam logic [rfpo_pkg::LIMB_IW-1:0] LAST = rfpo_pkg::LIMB_IW'(rfpo_pkg::LIMBS - 1);
	localparam int T_W = rfpo_pkg::LIMB_W + 8;

	logic [2:0]                      state_q;
	logic [rfpo_pkg::LIMB_W-1:0]     acc_q [rfpo_pkg::LIMBS];
	logic [rfpo_pkg::LIMB_W-1:0]     tr_q  [rfpo_pkg::LIMBS];
	logic [rfpo_pkg::LIMB_IW-1:0]    li_q;
	logic [7:0]                      pw_q;
	logic [7:0]                      carry_q;
	logic [7:0]                      g_q;
	logic [7:0]                      lo_q;
	logic [7:0]                      hi_q;
	logic [7:0]                      mid_q;
	logic [7:0]                      res_q;
	logic                            done_q;

	logic                            sel;
	logic [rfpo_pkg::LIMB_W-1:0]     a_op;
	logic [7:0]                      m_op;
	logic [T_W-1:0]                  t;
	logic [8:0]                      mid_sum;

	// shared limb multiplier
	assign sel     = (state_q == X_SMUL);
	assign a_op    = sel ? tr_q[li_q] : acc_q[li_q];
	assign m_op    = sel ? mid_q : g_q;
	assign t       = T_W'(a_op) * T_W'(m_op) + T_W'(carry_q);
	assign mid_sum = ({1'b0, lo_q} + {1'b0, hi_q} + 9'd1) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				X_IDLE: begin
					if (go) begin
						if (grey < 8'd2) begin
							done_q <= 1'b1;
						end else begin
							state_q <= X_TMUL;
						end
					end
				end
				X_TMUL: begin
					if (li_q == LAST) begin
						if (t[T_W-1:rfpo_pkg::LIMB_W] != 8'd0) begin
							done_q  <= 1'b1;
							state_q <= X_IDLE;
						end else if (pw_q == 8'd1) begin
							state_q <= X_SCHK;
						end
					end
				end
				X_SCHK: begin
					if (lo_q < hi_q) begin
						state_q <= X_SMUL;
					end else begin
						done_q  <= 1'b1;
						state_q <= X_IDLE;
					end
				end
				X_SMUL: begin
					if (li_q == LAST && pw_q == 8'd1) begin
						state_q <= X_CMP;
					end
				end
				X_CMP: begin
					if (tr_q[li_q] != acc_q[li_q] || li_q == '0) begin
						state_q <= X_SCHK;
					end
				end
				default: state_q <= X_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			X_IDLE: begin
				if (go) begin
					g_q     <= grey;
					res_q   <= grey;
					pw_q    <= expo;
					li_q    <= '0;
					carry_q <= 8'd0;
					for (int i = 0; i < rfpo_pkg::LIMBS; i++) begin
						acc_q[i] <= '0;
					end
					acc_q[0] <= rfpo_pkg::LIMB_W'(1);
				end
			end
			X_TMUL: begin
				acc_q[li_q] <= t[rfpo_pkg::LIMB_W-1:0];
				li_q        <= li_q + 1'b1;
				if (li_q == LAST) begin
					carry_q <= 8'd0;
					pw_q    <= pw_q - 8'd1;
					res_q   <= 8'd255;
					lo_q    <= g_q;
					hi_q    <= 8'd255;
				end else begin
					carry_q <= t[T_W-1:rfpo_pkg::LIMB_W];
				end
			end
			X_SCHK: begin
				res_q   <= lo_q;
				mid_q   <= mid_sum[7:0];
				pw_q    <= 8'd64;
				li_q    <= '0;
				carry_q <= 8'd0;
				for (int i = 0; i < rfpo_pkg::LIMBS; i++) begin
					tr_q[i] <= '0;
				end
				tr_q[0] <= rfpo_pkg::LIMB_W'(1);
			end
			X_SMUL: begin
				tr_q[li_q] <= t[rfpo_pkg::LIMB_W-1:0];
				if (li_q == LAST) begin
					carry_q <= 8'd0;
					pw_q    <= pw_q - 8'd1;
					// compare starts at the top limb
					li_q    <= (pw_q == 8'd1) ? LAST : '0;
				end else begin
					carry_q <= t[T_W-1:rfpo_pkg::LIMB_W];
					li_q    <= li_q + 1'b1;
				end
			end
			X_CMP: begin
				if (tr_q[li_q] != acc_q[li_q] || li_q == '0) begin
					if (tr_q[li_q] <= acc_q[li_q]) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q - 8'd1;
					end
				end else begin
					li_q <= li_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.busy   = (state_q != X_IDLE);
	assign rsp.result = res_q;

endmodule

/* src/rgb_frame_point_ops_rotate.sv */
// channel   | handshake              | payload
// input     | start / busy           | operation, red_in, green_in, blue_in
// result    | done (one-cycle pulse) | red_out, green_out, blue_out, is_grey, last_pixel
// config    | apb psel/penable/pwrite | paddr, pwdata, prdata
//
// a load runs S_TOT and S_CHK; an emit also runs S_IDX, S_RD, S_PIX and S_FIN, with a
// 21-step divider in rotate-90 mode; x-ray emits add the bignum power unit: about
// 16*e limb steps plus up to 8 search rounds of 64*16 limb steps and a compare
// arst_n clears the sequencer, counters and config registers; the store has no reset
// busy is high from accepted start to idle; loads give no done; results cannot stall
module rgb_frame_point_ops_rotate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        done,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        is_grey,
	output logic        last_pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "rgb_frame_point_ops_rotate_defines.svh"

	localparam int CW = rfpo_pkg::CNT_W;
	localparam int DW = rfpo_pkg::DIM_W;
	localparam int AW = rfpo_pkg::ADDR_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TOT  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_IDX  = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_PIX  = 4'd6;
	localparam logic [3:0] S_XGO  = 4'd7;
	localparam logic [3:0] S_XR   = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]    state_q;
	logic [2:0]    mode_q;
	logic [DW-1:0] fw_q;
	logic [DW-1:0] fh_q;
	logic [7:0]    pexp_q;
	logic [CW-1:0] load_cnt_q;
	logic [CW-1:0] emit_cnt_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [4:0]    dcnt_q;
	logic [AW-1:0] addr_q;
	logic          op_q;
	logic [rfpo_pkg::PIX_W-1:0] in_pix_q;
	logic [7:0]    r_q;
	logic [7:0]    g_q;
	logic [7:0]    b_q;
	logic [7:0]    grey_q;
	logic [7:0]    xres_q;
	logic          done_q;
	logic [7:0]    red_q;
	logic [7:0]    green_q;
	logic [7:0]    blue_q;
	logic          isg_q;
	logic          last_q;

	logic [DW-1:0]   w_c;
	logic [DW-1:0]   h_c;
	logic [7:0]      e_c;
	logic [2*DW-1:0] tot_w;
	logic [2*DW-1:0] rot_w;
	logic [DW-1:0]   row_w;
	logic [DW:0]     dtrial;
	logic            cfg_wr;
	logic            st_we;
	logic            st_re;
	logic [rfpo_pkg::PIX_W-1:0] st_rdata;
	logic [23:0]     grey_sum;
	logic [11:0]     r11;
	logic [11:0]     g11;
	logic [11:0]     b9;
	logic [27:0]     rq;
	logic [27:0]     gq;
	logic [27:0]     bq;
	logic            xr_go;
	logic            last_w;
	rfpo_pkg::xr_rsp_t xr_rsp;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rfpo_pkg::MODE_GREY;
			fw_q   <= DW'(rfpo_pkg::MAX_WIDTH);
			fh_q   <= DW'(rfpo_pkg::MAX_HEIGHT);
			pexp_q <= 8'd64;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				rfpo_pkg::REG_MODE:   mode_q <= pwdata[2:0];
				rfpo_pkg::REG_WIDTH:  fw_q   <= pwdata[DW-1:0];
				rfpo_pkg::REG_HEIGHT: fh_q   <= pwdata[DW-1:0];
				rfpo_pkg::REG_EXP:    pexp_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rfpo_pkg::REG_MODE:   prdata = {29'd0, mode_q};
			rfpo_pkg::REG_WIDTH:  prdata = {{(32-DW){1'b0}}, fw_q};
			rfpo_pkg::REG_HEIGHT: prdata = {{(32-DW){1'b0}}, fh_q};
			rfpo_pkg::REG_EXP:    prdata = {24'd0, pexp_q};
			default:              prdata = 32'd0;
		endcase
	end

	// clamped geometry and exponent
	assign w_c = (fw_q == '0) ? DW'(1) :
	             (fw_q > DW'(rfpo_pkg::MAX_WIDTH)) ? DW'(rfpo_pkg::MAX_WIDTH) : fw_q;
	assign h_c = (fh_q == '0) ? DW'(1) :
	             (fh_q > DW'(rfpo_pkg::MAX_HEIGHT)) ? DW'(rfpo_pkg::MAX_HEIGHT) : fh_q;
	assign e_c = (pexp_q < 8'd64) ? 8'd64 : (pexp_q > 8'd128) ? 8'd128 : pexp_q;

	assign tot_w  = (2*DW)'(w_c) * (2*DW)'(h_c);
	assign row_w  = h_c - DW'(1) - rem_q;
	assign rot_w  = (2*DW)'(row_w) * (2*DW)'(w_c) + (2*DW)'(quo_q);
	assign dtrial = {rem_q, quo_q[CW-1]};

	// pixel math
	assign grey_sum = 24'd19595 * 24'(st_rdata[23:16]) + 24'd38470 * 24'(st_rdata[15:8])
	                + 24'd7471 * 24'(st_rdata[7:0]);
	assign r11 = 12'd11 * 12'(r_q);
	assign g11 = 12'd11 * 12'(g_q);
	assign b9  = 12'd9 * 12'(b_q);
	assign rq  = 28'(r11) * 28'd6554;
	assign gq  = 28'(g11) * 28'd6554;
	assign bq  = 28'(b9) * 28'd6554;

	assign last_w = (n_q == total_q - CW'(1));
	assign st_we  = (state_q == S_CHK) && !op_q && (load_cnt_q < total_q);
	assign st_re  = (state_q == S_RD);
	assign xr_go  = (state_q == S_XGO);

	rfpo_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (load_cnt_q[AW-1:0]),
		.wdata (in_pix_q),
		.re    (st_re),
		.raddr (addr_q),
		.rdata (st_rdata)
	);

	rfpo_xray u_xray (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (xr_go),
		.grey   (grey_q),
		.expo   (e_c),
		.rsp    (xr_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			load_cnt_q <= '0;
			emit_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_TOT;
					end
				end
				S_TOT: state_q <= S_CHK;
				S_CHK: begin
					if (!op_q) begin
						if (load_cnt_q < total_q) begin
							load_cnt_q <= load_cnt_q + CW'(1);
						end
						state_q <= S_IDLE;
					end else if (mode_q == rfpo_pkg::MODE_ROT90) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_IDX;
					end
				end
				S_DIV: begin
					if (dcnt_q == 5'd1) begin
						state_q <= S_IDX;
					end
				end
				S_IDX: state_q <= S_RD;
				S_RD:  state_q <= S_PIX;
				S_PIX: state_q <= (mode_q == rfpo_pkg::MODE_XRAY) ? S_XGO : S_FIN;
				S_XGO: state_q <= S_XR;
				S_XR: begin
					if (xr_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q <= 1'b1;
					if (last_w) begin
						emit_cnt_q <= '0;
						load_cnt_q <= '0;
					end else begin
						emit_cnt_q <= n_q + CW'(1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q     <= operation;
					in_pix_q <= {red_in, green_in, blue_in};
				end
			end
			S_TOT: total_q <= tot_w[CW-1:0];
			S_CHK: begin
				n_q    <= (emit_cnt_q >= total_q) ? '0 : emit_cnt_q;
				quo_q  <= (emit_cnt_q >= total_q) ? '0 : emit_cnt_q;
				rem_q  <= '0;
				dcnt_q <= 5'(CW);
			end
			S_DIV: begin
				dcnt_q <= dcnt_q - 5'd1;
				if (dtrial >= {1'b0, h_c}) begin
					rem_q <= DW'(dtrial - {1'b0, h_c});
					quo_q <= {quo_q[CW-2:0], 1'b1};
				end else begin
					rem_q <= dtrial[DW-1:0];
					quo_q <= {quo_q[CW-2:0], 1'b0};
				end
			end
			S_IDX: begin
				case (mode_q)
					rfpo_pkg::MODE_ROT90:  addr_q <= rot_w[AW-1:0];
					rfpo_pkg::MODE_ROT180: addr_q <= AW'(total_q - CW'(1) - n_q);
					default:               addr_q <= n_q[AW-1:0];
				endcase
			end
			S_PIX: begin
				r_q    <= st_rdata[23:16];
				g_q    <= st_rdata[15:8];
				b_q    <= st_rdata[7:0];
				grey_q <= grey_sum[23:16];
			end
			S_XR: begin
				if (xr_rsp.done) begin
					xres_q <= xr_rsp.result;
				end
			end
			S_FIN: begin
				last_q <= last_w;
				isg_q  <= 1'b0;
				case (mode_q)
					rfpo_pkg::MODE_GREY: begin
						red_q   <= grey_q;
						green_q <= 8'd0;
						blue_q  <= 8'd0;
						isg_q   <= 1'b1;
					end
					rfpo_pkg::MODE_NEG: begin
						red_q   <= ~r_q;
						green_q <= ~g_q;
						blue_q  <= ~b_q;
					end
					rfpo_pkg::MODE_XRAY: begin
						red_q   <= xres_q;
						green_q <= 8'd0;
						blue_q  <= 8'd0;
						isg_q   <= 1'b1;
					end
					rfpo_pkg::MODE_TINT: begin
						red_q   <= (rq[27:16] > 12'd255) ? 8'd255 : rq[23:16];
						green_q <= (gq[27:16] > 12'd255) ? 8'd255 : gq[23:16];
						blue_q  <= bq[23:16];
					end
					default: begin
						red_q   <= r_q;
						green_q <= g_q;
						blue_q  <= b_q;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign red_out    = red_q;
	assign green_out  = green_q;
	assign blue_out   = blue_q;
	assign is_grey    = isg_q;
	assign last_pixel = last_q;

	`RFPO_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`RFPO_ASSERT_IMP(a_done_after_fin, done, $past(state_q) == S_FIN, "result pulse without finish step")
	`RFPO_ASSERT_IMP(a_last_clears, done && last_pixel, emit_cnt_q == '0 && load_cnt_q == '0,
		"frame counters not cleared after last pixel")

endmodule
